[rtl/core/tcpq_pkg.sv]
// Shared types and constants for the two-class priority queue.
// Holds the payload structs, command and status codes and store sizing.
// No dependencies.
package tcpq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_ENQ_NORMAL   = 2'd0;
  localparam logic [1:0] CMD_ENQ_CRITICAL = 2'd1;
  localparam logic [1:0] CMD_DEQUEUE      = 2'd2;
  localparam logic [1:0] CMD_CANCEL       = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] entry_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] removed_key;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] critical_count;
  } out_item_t;

endpackage

[rtl/core/tcpq_key_store.sv]
// Key store for the two-class priority queue: one write port, one read
// port with registered read data. Depends on tcpq_pkg for sizing.
module tcpq_key_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [tcpq_pkg::ADDR_W-1:0] wr_addr,
  input  logic [tcpq_pkg::KEY_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [tcpq_pkg::ADDR_W-1:0] rd_addr,
  output logic [tcpq_pkg::KEY_W-1:0]  rd_data
);

  logic [tcpq_pkg::KEY_W-1:0] mem_r [tcpq_pkg::CAPACITY];
  logic [tcpq_pkg::KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/two_class_priority_queue_unit.sv]
// Two-class priority queue: ordered key store plus a small sequencer that
// searches and shifts one entry per cycle. Depends on tcpq_pkg, tcpq_key_store.
// Usage:
//   in_valid/in_ready/in_data carry one command (enqueue normal, enqueue
//   critical, dequeue head, cancel by key) per transfer. out_valid/out_ready/
//   out_data return exactly one result per command: status, removed key and
//   the entry and critical counts after the command.
//   The block takes one command at a time; in_ready is high only while the
//   sequencer is idle; a new command waits until the last result is loaded.
// Steps per command, with N entries held, C of them critical:
//   normal enqueue, or a command rejected on an empty or full queue: straight
//   to the result. critical enqueue: each of the N - C normal entries moves
//   up a slot, the last move drains, the key is written, the result is loaded.
//   dequeue: head read, then close the gap.
//   cancel: scan from the head; a hit closes the gap behind it, a miss scans
//   all N entries.
// The output register holds a finished result while the receiver stalls;
// the next command is still taken, runs to its result, then waits there.
// Reset (synchronous, active low) empties the queue and clears the counts;
// the key store itself is not cleared, entries past the count are never read.
module two_class_priority_queue_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcpq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcpq_pkg::out_item_t  out_data
);

  localparam int AW = tcpq_pkg::ADDR_W;
  localparam int CW = tcpq_pkg::CNT_W;
  localparam int KW = tcpq_pkg::KEY_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;  // open a gap for a critical insert
  localparam logic [2:0] S_DOWN   = 3'd2;  // close a gap after a removal
  localparam logic [2:0] S_SEARCH = 3'd3;  // scan for a cancel key
  localparam logic [2:0] S_HEAD   = 3'd4;  // head read in flight
  localparam logic [2:0] S_DONE   = 3'd5;  // result waits for the output reg

  logic [2:0]    state_r,    state_nxt;
  logic [CW-1:0] held_r,     held_nxt;
  logic [CW-1:0] crit_r,     crit_nxt;
  logic [CW-1:0] idx_r,      idx_nxt;
  logic          pend_r,     pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          rvalid_r,   rvalid_nxt;
  logic [AW-1:0] cmp_addr_r, cmp_addr_nxt;
  logic [KW-1:0] key_r,      key_nxt;
  logic [1:0]    status_r,   status_nxt;
  logic [KW-1:0] removed_r,  removed_nxt;
  logic          out_valid_r, out_valid_nxt;
  tcpq_pkg::out_item_t out_r, out_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] rd_data;

  logic          full;
  logic          empty;
  logic          accept;

  tcpq_key_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign full     = (held_r == CW'(tcpq_pkg::CAPACITY));
  assign empty    = (held_r == '0);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    crit_nxt      = crit_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    rvalid_nxt    = 1'b0;
    cmp_addr_nxt  = cmp_addr_r;
    key_nxt       = key_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    // A pending shift write always owns the write port.
    wr_en   = pend_r;
    wr_addr = pend_addr_r;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = '0;

    // Drop the result once the receiver takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt     = in_data.entry_key;
          removed_nxt = '0;
          status_nxt  = tcpq_pkg::ST_OK;
          case (in_data.cmd)
            tcpq_pkg::CMD_ENQ_NORMAL: begin
              state_nxt = S_DONE;
              if (full) begin
                status_nxt = tcpq_pkg::ST_FULL;
              end else begin
                // Append at the tail right away.
                wr_en    = 1'b1;
                wr_addr  = held_r[AW-1:0];
                wr_data  = in_data.entry_key;
                held_nxt = held_r + CW'(1);
              end
            end
            tcpq_pkg::CMD_ENQ_CRITICAL: begin
              if (full) begin
                status_nxt = tcpq_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt   = held_r;
                state_nxt = S_UP;
              end
            end
            tcpq_pkg::CMD_DEQUEUE: begin
              if (empty) begin
                status_nxt = tcpq_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_HEAD;
              end
            end
            default: begin
              if (empty) begin
                status_nxt = tcpq_pkg::ST_NOT_FOUND;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
          endcase
        end
      end

      S_UP: begin
        if (idx_r > crit_r) begin
          // Move entry idx-1 up to idx.
          rd_en         = 1'b1;
          rd_addr       = AW'(idx_r - CW'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_r - CW'(1);
        end else if (!pend_r) begin
          // Gap is open at the end of the critical region.
          wr_en     = 1'b1;
          wr_addr   = crit_r[AW-1:0];
          wr_data   = key_r;
          held_nxt  = held_r + CW'(1);
          crit_nxt  = crit_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_HEAD: begin
        removed_nxt = rd_data;
        if (crit_r != '0) begin
          crit_nxt = crit_r - CW'(1);
        end
        idx_nxt   = '0;
        state_nxt = S_DOWN;
      end

      S_SEARCH: begin
        if (rvalid_r && (rd_data == key_r)) begin
          // First match from the head: remove it.
          if ({1'b0, cmp_addr_r} < crit_r) begin
            crit_nxt = crit_r - CW'(1);
          end
          idx_nxt   = {1'b0, cmp_addr_r};
          state_nxt = S_DOWN;
        end else if (idx_r < held_r) begin
          rd_en        = 1'b1;
          rd_addr      = idx_r[AW-1:0];
          rvalid_nxt   = 1'b1;
          cmp_addr_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + CW'(1);
        end else if (!rvalid_r) begin
          status_nxt = tcpq_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end
      end

      S_DOWN: begin
        if ((idx_r + CW'(1)) < held_r) begin
          // Move entry idx+1 down to idx.
          rd_en         = 1'b1;
          rd_addr       = AW'(idx_r + CW'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_r + CW'(1);
        end else if (!pend_r) begin
          held_nxt  = held_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = status_r;
          out_nxt.removed_key    = removed_r;
          out_nxt.entry_count    = held_r;
          out_nxt.critical_count = crit_r;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      crit_r      <= '0;
      pend_r      <= 1'b0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      crit_r      <= crit_nxt;
      pend_r      <= pend_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    cmp_addr_r  <= cmp_addr_nxt;
    key_r       <= key_nxt;
    status_r    <= status_nxt;
    removed_r   <= removed_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[bench/two_class_priority_queue_unit_tb.sv]
// Self-checking bench for two_class_priority_queue_unit: a scripted opening,
// then biased random commands; checked against a behavioral queue and hand-typed rows.
// Depends on tcpq_pkg and the two_class_priority_queue_unit RTL.
module two_class_priority_queue_unit_tb;

  localparam int KW  = tcpq_pkg::KEY_W;
  localparam int CW  = tcpq_pkg::CNT_W;
  localparam int CAP = tcpq_pkg::CAPACITY;

  localparam int RANDOM_ITEMS  = 1870;
  localparam int QUIET_ITEMS   = 150;   // tail of the run with no idling
  localparam int HOLD_AT       = 300;   // random item that starts the long receiver stall
  localparam int HOLD_CYCLES   = 400;
  localparam int PAUSE_AT      = 1000;  // random item before which the sender drains
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 60;    // longer than a full-queue cancel miss

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_EVEN} bias_t;

  // One scripted row: a command, its key, a repeat count (the key steps by one
  // per repeat) and, where it is obvious, the result typed in by hand.
  typedef struct packed {
    logic [1:0]          cmd;
    logic [KW-1:0]       key;
    logic [4:0]          reps;
    logic                typed;
    tcpq_pkg::out_item_t want;
  } script_row_t;

  localparam tcpq_pkg::out_item_t FROM_QUEUE = '0;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tcpq_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tcpq_pkg::out_item_t out_data;

  // Hand-typed result that travels with the item on the input channel.
  logic                typed_flag;
  tcpq_pkg::out_item_t typed_result;

  // Behavioral copy of the queue: keys from head to tail, critical ones first.
  logic [KW-1:0]       held_keys[$];
  int                  crit_held;
  tcpq_pkg::out_item_t owed_results[$];

  int  mismatches;
  int  cmd_tally[4];
  int  status_tally[4];
  int  peak_fill;
  bit  quiet;
  bit  hold_req;
  bit  hold_done;

  script_row_t script [16] = '{
    // dequeue and cancel on an empty queue
    '{tcpq_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF, 5'd1, 1'b1,
      '{tcpq_pkg::ST_EMPTY, 32'h0, 5'd0, 5'd0}},
    '{tcpq_pkg::CMD_CANCEL, 32'h0000_0000, 5'd1, 1'b1,
      '{tcpq_pkg::ST_NOT_FOUND, 32'h0, 5'd0, 5'd0}},
    // key extremes, both classes
    '{tcpq_pkg::CMD_ENQ_NORMAL, 32'h0000_0000, 5'd1, 1'b1,
      '{tcpq_pkg::ST_OK, 32'h0, 5'd1, 5'd0}},
    '{tcpq_pkg::CMD_ENQ_NORMAL, 32'hFFFF_FFFF, 5'd1, 1'b1,
      '{tcpq_pkg::ST_OK, 32'h0, 5'd2, 5'd0}},
    '{tcpq_pkg::CMD_ENQ_CRITICAL, 32'hA5A5_A5A5, 5'd1, 1'b1,
      '{tcpq_pkg::ST_OK, 32'h0, 5'd3, 5'd1}},
    '{tcpq_pkg::CMD_ENQ_CRITICAL, 32'h5A5A_5A5A, 5'd1, 1'b0, FROM_QUEUE},
    // cancel that misses on a non-empty queue
    '{tcpq_pkg::CMD_CANCEL, 32'h1234_5678, 5'd1, 1'b1,
      '{tcpq_pkg::ST_NOT_FOUND, 32'h0, 5'd4, 5'd2}},
    // duplicate key: only the first match from the head goes
    '{tcpq_pkg::CMD_ENQ_NORMAL, 32'h0000_0000, 5'd1, 1'b0, FROM_QUEUE},
    '{tcpq_pkg::CMD_CANCEL, 32'h0000_0000, 5'd1, 1'b0, FROM_QUEUE},
    // cancel inside the critical region
    '{tcpq_pkg::CMD_CANCEL, 32'h5A5A_5A5A, 5'd1, 1'b0, FROM_QUEUE},
    // dequeue of a critical head, then with no critical entries left
    '{tcpq_pkg::CMD_DEQUEUE, 32'hDEAD_BEEF, 5'd1, 1'b0, FROM_QUEUE},
    '{tcpq_pkg::CMD_DEQUEUE, 32'h0000_0000, 5'd1, 1'b0, FROM_QUEUE},
    // fill to capacity with critical entries, then reject both classes
    '{tcpq_pkg::CMD_ENQ_CRITICAL, 32'h8000_0000, 5'd15, 1'b0, FROM_QUEUE},
    '{tcpq_pkg::CMD_ENQ_NORMAL, 32'h0000_0000, 5'd1, 1'b1,
      '{tcpq_pkg::ST_FULL, 32'h0, 5'd16, 5'd15}},
    '{tcpq_pkg::CMD_ENQ_CRITICAL, 32'hFFFF_FFFF, 5'd1, 1'b1,
      '{tcpq_pkg::ST_FULL, 32'h0, 5'd16, 5'd15}},
    '{tcpq_pkg::CMD_CANCEL, 32'h0000_0000, 5'd1, 1'b0, FROM_QUEUE}
  };

  two_class_priority_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the behavioral queue and return the result it owes.
  function automatic tcpq_pkg::out_item_t run_command(tcpq_pkg::in_item_t item);
    tcpq_pkg::out_item_t res;
    int                  hit;
    res        = '0;
    res.status = tcpq_pkg::ST_OK;
    hit        = -1;
    case (item.cmd)
      tcpq_pkg::CMD_ENQ_NORMAL: begin
        if (held_keys.size() >= CAP) res.status = tcpq_pkg::ST_FULL;
        else held_keys.push_back(item.entry_key);
      end
      tcpq_pkg::CMD_ENQ_CRITICAL: begin
        // slot in behind the last critical entry
        if (held_keys.size() >= CAP) begin
          res.status = tcpq_pkg::ST_FULL;
        end else begin
          held_keys.insert(crit_held, item.entry_key);
          crit_held++;
        end
      end
      tcpq_pkg::CMD_DEQUEUE: begin
        if (held_keys.size() == 0) begin
          res.status = tcpq_pkg::ST_EMPTY;
        end else begin
          res.removed_key = held_keys.pop_front();
          if (crit_held > 0) crit_held--;
        end
      end
      default: begin
        // search from the head, drop the first match only
        for (int i = 0; i < held_keys.size() && hit < 0; i++) begin
          if (held_keys[i] == item.entry_key) hit = i;
        end
        if (hit < 0) begin
          res.status = tcpq_pkg::ST_NOT_FOUND;
        end else begin
          held_keys.delete(hit);
          if (hit < crit_held) crit_held--;
        end
      end
    endcase
    res.entry_count    = CW'(held_keys.size());
    res.critical_count = CW'(crit_held);
    return res;
  endfunction

  // Draw a random command. Keys come from a small pool often enough to make
  // duplicates, and cancels mostly name a key that is actually queued.
  function automatic tcpq_pkg::in_item_t pick_command(bias_t bias);
    tcpq_pkg::in_item_t item;
    int                 roll;
    int                 pick;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  item.cmd = roll < 40 ? tcpq_pkg::CMD_ENQ_NORMAL :
                             roll < 75 ? tcpq_pkg::CMD_ENQ_CRITICAL :
                             roll < 88 ? tcpq_pkg::CMD_DEQUEUE : tcpq_pkg::CMD_CANCEL;
      BIAS_DRAIN: item.cmd = roll < 15 ? tcpq_pkg::CMD_ENQ_NORMAL :
                             roll < 25 ? tcpq_pkg::CMD_ENQ_CRITICAL :
                             roll < 65 ? tcpq_pkg::CMD_DEQUEUE : tcpq_pkg::CMD_CANCEL;
      default:    item.cmd = roll < 25 ? tcpq_pkg::CMD_ENQ_NORMAL :
                             roll < 45 ? tcpq_pkg::CMD_ENQ_CRITICAL :
                             roll < 73 ? tcpq_pkg::CMD_DEQUEUE : tcpq_pkg::CMD_CANCEL;
    endcase
    pick = $urandom_range(0, 99);
    if (item.cmd == tcpq_pkg::CMD_CANCEL && held_keys.size() != 0 && pick < 60)
      item.entry_key = held_keys[$urandom_range(0, held_keys.size() - 1)];
    else if (pick < 75)
      item.entry_key = KW'($urandom_range(0, 7));
    else if (pick < 82)
      item.entry_key = {KW{1'b1}} - KW'($urandom_range(0, 7));
    else
      item.entry_key = KW'($urandom());
    return item;
  endfunction

  task automatic compare_result(tcpq_pkg::out_item_t want, tcpq_pkg::out_item_t got);
    if (got.status !== want.status) begin
      mismatches++;
      $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
    end
    if (got.removed_key !== want.removed_key) begin
      mismatches++;
      $display("%0t: removed_key expected %h, actual %h", $time, want.removed_key,
               got.removed_key);
    end
    if (got.entry_count !== want.entry_count) begin
      mismatches++;
      $display("%0t: entry_count expected %0d, actual %0d", $time, want.entry_count,
               got.entry_count);
    end
    if (got.critical_count !== want.critical_count) begin
      mismatches++;
      $display("%0t: critical_count expected %0d, actual %0d", $time, want.critical_count,
               got.critical_count);
    end
  endtask

  // Sample both channels at the rising edge. Retire the result first so a
  // result arriving with nothing owed is caught before a new item is logged.
  always @(posedge clk) begin
    tcpq_pkg::out_item_t owed;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        status_tally[out_data.status]++;
        if (int'(out_data.entry_count) > peak_fill) peak_fill = int'(out_data.entry_count);
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing owed, actual %p", $time, out_data);
        end else begin
          owed = owed_results.pop_front();
          compare_result(owed, out_data);
        end
      end
      if (in_valid && in_ready) begin
        cmd_tally[in_data.cmd]++;
        owed = run_command(in_data);
        owed_results.push_back(typed_flag ? typed_result : owed);
      end
    end
  end

  // Drop valid for a burst of idle cycles.
  task automatic idle_for(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Present one item at the falling edge and hold it until the transfer.
  task automatic offer(bit draw, bias_t bias, tcpq_pkg::in_item_t item, bit typed,
                       tcpq_pkg::out_item_t want);
    @(negedge clk);
    if (draw) item = pick_command(bias);
    in_valid     <= 1'b1;
    in_data      <= item;
    typed_flag   <= typed;
    typed_result <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Receiver: random ready/stall bursts, one long stall to back the block up,
  // always ready in the quiet tail.
  initial begin
    int span;
    bit ready_next;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        ready_next = 1'b1;
        span       = 1;
      end else if (hold_req && !hold_done) begin
        ready_next = 1'b0;
        span       = HOLD_CYCLES;
        hold_done  = 1'b1;
      end else if ($urandom_range(0, 99) < 35) begin
        ready_next = 1'b0;
        span       = $urandom_range(1, 18);
      end else begin
        ready_next = 1'b1;
        span       = $urandom_range(1, 40);
      end
      @(negedge clk);
      out_ready <= ready_next;
      repeat (span - 1) @(negedge clk);
    end
  end

  // Sender and end of run.
  initial begin
    tcpq_pkg::in_item_t item;
    bias_t              bias;
    int                 gap_pct;
    int                 block_left;
    int                 waited;
    in_valid     = 1'b0;
    in_data      = '0;
    typed_flag   = 1'b0;
    typed_result = '0;
    mismatches   = 0;
    crit_held    = 0;
    peak_fill    = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    block_left   = 0;
    bias         = BIAS_EVEN;
    gap_pct      = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Scripted opening: walk the table, stepping the key on repeated rows.
    foreach (script[r]) begin
      for (int i = 0; i < script[r].reps; i++) begin
        item.cmd       = script[r].cmd;
        item.entry_key = script[r].key + KW'(i);
        if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 18));
        offer(1'b0, BIAS_EVEN, item, script[r].typed, script[r].want);
      end
    end

    // Random part in blocks that lean toward filling, draining or neither, so
    // the queue swings between empty and full; gap density changes per block.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (block_left == 0) begin
        bias       = bias_t'($urandom_range(0, 2));
        gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 10 : 40);
        block_left = $urandom_range(20, 80);
      end
      block_left--;
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        // hold off until every owed result is back
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
      end
      if (!quiet && $urandom_range(0, 99) < gap_pct) idle_for($urandom_range(1, 18));
      offer(1'b1, bias, item, 1'b0, FROM_QUEUE);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // let any stray extra result show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results expected but never arrived", $time, owed_results.size());
    end

    $display("Ran %0d normal / %0d critical enqueues, %0d dequeues, %0d cancels;",
             cmd_tally[tcpq_pkg::CMD_ENQ_NORMAL], cmd_tally[tcpq_pkg::CMD_ENQ_CRITICAL],
             cmd_tally[tcpq_pkg::CMD_DEQUEUE], cmd_tally[tcpq_pkg::CMD_CANCEL]);
    $display("peak fill %0d of %0d; outcomes seen: ok %0d, empty %0d, not found %0d, full %0d",
             peak_fill, CAP, status_tally[tcpq_pkg::ST_OK], status_tally[tcpq_pkg::ST_EMPTY],
             status_tally[tcpq_pkg::ST_NOT_FOUND], status_tally[tcpq_pkg::ST_FULL]);
    if (mismatches == 0) begin
      $display("two_class_priority_queue_unit verification clean");
    end else begin
      $display("two_class_priority_queue_unit verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("two_class_priority_queue_unit verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_key_store.sv
rtl/core/two_class_priority_queue_unit.sv
bench/two_class_priority_queue_unit_tb.sv
